// File: hw/rtl/pafd_pkg.sv
package pafd_pkg;

  // Window entries are saturated to 20 bits before they are stored.
  localparam int INTERVAL_W = 20;
  localparam logic [INTERVAL_W-1:0] INTERVAL_CAP = 20'hFFFFF;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHI_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STD       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_EST     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEN    = 3'd3;

  localparam logic [15:0] PHI_THRESHOLD_RST = 16'd2048;
  localparam logic [15:0] MIN_STD_RST       = 16'd100;
  localparam logic [15:0] FIRST_EST_RST     = 16'd1000;
  localparam logic [7:0]  WINDOW_LEN_RST    = 8'd128;

  // Seed state for the reset estimate of 1000 ms: 750 and 1250.
  localparam logic [INTERVAL_W-1:0] SEED_LO  = 20'd750;
  localparam logic [INTERVAL_W-1:0] SEED_HI  = 20'd1250;
  localparam logic [39:0]           SEED_SUM = 40'd2000;
  localparam logic [63:0]           SEED_SQ  = 64'd2125000;

  // Fixed-point constants
  localparam logic [31:0] COEF_A_Q16  = 32'd104700;
  localparam logic [31:0] COEF_B_Q16  = 32'd4625;
  localparam logic [31:0] LN2_Q30     = 32'd744261118;
  localparam logic [31:0] LN10_Q30    = 32'd2472381918;
  localparam logic [31:0] INF_T_Q16   = 32'd6815744;
  localparam logic [31:0] Y_MAX_Q16   = 32'd1048576;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] TWO_Q30     = 32'h8000_0000;
  localparam logic [63:0] EXP_K_LIMIT = 64'd31;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd14;
  localparam logic [3:0]  ATANH_LAST   = 4'd11;
  localparam logic [15:0] PHI_SAT      = 16'hFFFF;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

// File: hw/rtl/pafd_ram.sv
module pafd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pafd_div.sv
module pafd_div import pafd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle
  logic        busy;
  logic        done;
  logic [5:0]  step;
  logic [31:0] divisor;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        fits;

  always_comb begin
    shifted = {rem, quo[63]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem  <= fits ? diff[31:0] : shifted[31:0];
        quo  <= {quo[62:0], fits};
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy    <= 1'b1;
        step    <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end
    end
  end

  assign rsp = '{done: done, quot: quo, rem: rem};

endmodule

// File: hw/rtl/pafd_isqrt.sv
module pafd_isqrt import pafd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  // digit-by-digit square root, one result bit per cycle
  logic        busy;
  logic        done;
  logic [4:0]  step;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        ge;

  always_comb begin
    trial = r + bitv;
    ge    = v >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        v    <= ge ? v - trial : v;
        r    <= ge ? (r >> 1) + bitv : r >> 1;
        bitv <= bitv >> 2;
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        v    <= req.radicand;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end
    end
  end

  assign rsp = '{done: done, root: r[31:0]};

endmodule

// File: hw/rtl/phi_accrual_failure_detector.sv
// Phi accrual failure detector, one item in flight at a time.
// When phi is evaluated, 33 divisions go through the 64-step shared divider; none when no
//   heartbeat has been seen. A heartbeat adds S_APP, S_WR, S_WR2 per appended interval
//   and S_APP, S_EV1, S_EV2 per window entry dropped. A new item waits for the last result.
// Reset: registers take their defaults, then S_INIT0 and S_INIT1 write the seed intervals
//   into the window memory while input is stalled; config writes are taken throughout.
module phi_accrual_failure_detector import pafd_pkg::*; #(
  parameter int WINDOW_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [47:0]            now_ms,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            phi_level,
  output logic                   available,
  output logic                   interval_taken,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int EXT_W  = CNT_W + 1;

  typedef enum logic [5:0] {
    S_INIT0, S_INIT1, S_IDLE,
    S_MEAN, S_MEAN_R, S_SQ1, S_SQ2, S_SQ3, S_SQ4,
    S_VAR1, S_VAR2, S_SQRTW,
    S_Y, S_YR, S_Y2, S_Y3, S_Y4, S_Y5,
    S_EXP0, S_EXP1, S_EXP2, S_EXP3, S_EXP4,
    S_LN0, S_LN1, S_LN2, S_LN3, S_LN4, S_LN5,
    S_PHI, S_PHIR, S_AVAIL, S_UPD,
    S_APP, S_EV1, S_EV2, S_WR, S_WR2, S_OUT,
    S_DIVW
  } state_t;

  state_t state;
  state_t ret_state;

  // configuration registers
  logic [15:0] phi_threshold;
  logic [15:0] min_std_deviation;
  logic [15:0] first_interval_estimate;
  logic [7:0]  window_length;

  // detector state
  logic [ADDR_W-1:0] write_slot;
  logic [CNT_W-1:0]  sample_count;
  logic [39:0]       interval_sum;
  logic [63:0]       interval_square_sum;
  logic [47:0]       last_beat_time;

  // per-item working registers
  logic                  cmd;
  logic [47:0]           now;
  logic [47:0]           elapsed;
  logic [39:0]           mean_q8;
  logic [63:0]           acc;
  logic [63:0]           d;
  logic [31:0]           nn;
  logic [63:0]           var_q16;
  logic [31:0]           std_q8;
  logic                  neg;
  logic [31:0]           y;
  logic [63:0]           x;
  logic [4:0]            k;
  logic [31:0]           r;
  logic [31:0]           term;
  logic [33:0]           s;
  logic [3:0]            it;
  logic [31:0]           u;
  logic [31:0]           z2;
  logic [31:0]           p;
  logic [39:0]           ls;
  logic [15:0]           phi;
  logic                  avail;
  logic                  taken;
  logic                  seed_second;
  logic [INTERVAL_W-1:0] app_v;
  logic [INTERVAL_W-1:0] old;

  // shared multiplier: operands picked by state, product registered
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [INTERVAL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [INTERVAL_W-1:0] ram_rdata;

  // combinational helpers
  logic [CNT_W-1:0]  eff_len;
  logic [EXT_W-1:0]  slot_ext;
  logic [EXT_W-1:0]  cnt_ext;
  logic [EXT_W-1:0]  idx_ext;
  logic [31:0]       floor_q8;
  logic [63:0]       el_q8;
  logic [63:0]       mean64;
  logic              neg_c;
  logic [63:0]       mag_c;
  logic              y_big;
  logic [31:0]       tm_c;
  logic [63:0]       x_c;
  logic [63:0]       var_c;
  logic [63:0]       total_c;
  logic [15:0]       est_q;

  pafd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pafd_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  pafd_ram #(
    .WIDTH (INTERVAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // window length clamped to [2, WINDOW_DEPTH]
  always_comb begin
    if (window_length < 8'd2) begin
      eff_len = CNT_W'(2);
    end else if (32'(window_length) > WINDOW_DEPTH) begin
      eff_len = CNT_W'(WINDOW_DEPTH);
    end else begin
      eff_len = CNT_W'(window_length);
    end
  end

  // oldest entry sits sample_count slots behind the write slot
  always_comb begin
    slot_ext = EXT_W'(write_slot);
    cnt_ext  = EXT_W'(sample_count);
    if (slot_ext >= cnt_ext) begin
      idx_ext = slot_ext - cnt_ext;
    end else begin
      idx_ext = slot_ext + EXT_W'(WINDOW_DEPTH) - cnt_ext;
    end
    ram_raddr = idx_ext[ADDR_W-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_slot;
    ram_wdata = app_v;
    case (state)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = SEED_LO;
      end
      S_INIT1: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(1);
        ram_wdata = SEED_HI;
      end
      S_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MEAN_R: begin
        mul_a = 32'(sample_count);
        mul_b = interval_square_sum[31:0];
      end
      S_SQ1: begin
        mul_a = 32'(sample_count);
        mul_b = interval_square_sum[63:32];
      end
      S_SQ2: begin
        mul_a = interval_sum[31:0];
        mul_b = interval_sum[31:0];
      end
      S_SQ3: begin
        mul_a = 32'(sample_count);
        mul_b = 32'(sample_count);
      end
      S_Y2: begin
        mul_a = y;
        mul_b = y;
      end
      S_Y3: begin
        mul_a = COEF_B_Q16;
        mul_b = mul_p[47:16];
      end
      S_Y4: begin
        mul_a = y;
        mul_b = COEF_A_Q16 + mul_p[47:16];
      end
      S_EXP1: begin
        mul_a = term;
        mul_b = r;
      end
      S_LN1: begin
        mul_a = div_rsp.quot[31:0];
        mul_b = div_rsp.quot[31:0];
      end
      S_LN4: begin
        mul_a = p;
        mul_b = z2;
      end
      S_EV1: begin
        mul_a = 32'(ram_rdata);
        mul_b = 32'(ram_rdata);
      end
      S_WR: begin
        mul_a = 32'(app_v);
        mul_b = 32'(app_v);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_comb begin
    floor_q8 = (min_std_deviation == 16'd0) ? 32'h0000_0100 : {8'd0, min_std_deviation, 8'd0};
    el_q8    = {8'd0, elapsed, 8'd0};
    mean64   = 64'(mean_q8);
    neg_c    = el_q8 < mean64;
    mag_c    = neg_c ? mean64 - el_q8 : el_q8 - mean64;
    y_big    = mag_c >= {28'd0, std_q8, 4'd0};
    tm_c     = mul_p[47:16];
    x_c      = {18'd0, tm_c, 14'd0};
    var_c    = var_q16 + div_rsp.quot;
    total_c  = (neg ? 64'd0 : x) + {23'd0, ls, 1'b0};
    est_q    = first_interval_estimate >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phi_threshold           <= PHI_THRESHOLD_RST;
      min_std_deviation       <= MIN_STD_RST;
      first_interval_estimate <= FIRST_EST_RST;
      window_length           <= WINDOW_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHI_THRESHOLD: phi_threshold           <= cfg_data;
        CFG_MIN_STD:       min_std_deviation       <= cfg_data;
        CFG_FIRST_EST:     first_interval_estimate <= cfg_data;
        CFG_WINDOW_LEN:    window_length           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer. Divisions go out through div_req and park in S_DIVW, which
  // returns to ret_state with the quotient held on div_rsp.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_INIT0;
      ret_state           <= S_IDLE;
      write_slot          <= ADDR_W'(2 % WINDOW_DEPTH);
      sample_count        <= CNT_W'(2);
      interval_sum        <= SEED_SUM;
      interval_square_sum <= SEED_SQ;
      last_beat_time      <= '0;
      out_valid           <= 1'b0;
      seed_second         <= 1'b0;
      div_req.start       <= 1'b0;
      sqrt_req.start      <= 1'b0;
    end else begin
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT0: state <= S_INIT1;
        S_INIT1: state <= S_IDLE;

        S_IDLE: begin
          if (in_valid) begin
            cmd     <= command;
            now     <= now_ms;
            elapsed <= (now_ms >= last_beat_time) ? now_ms - last_beat_time : 48'd0;
            taken   <= 1'b0;
            if (last_beat_time == 48'd0) begin
              phi   <= '0;
              state <= S_AVAIL;
            end else begin
              state <= S_MEAN;
            end
          end
        end

        // mean in Q.8
        S_MEAN: begin
          div_req   <= '{start: 1'b1, dividend: {16'd0, interval_sum, 8'd0},
                         divisor: 32'(sample_count)};
          ret_state <= S_MEAN_R;
          state     <= S_DIVW;
        end
        S_MEAN_R: begin
          mean_q8 <= div_rsp.quot[39:0];
          state   <= S_SQ1;
        end

        // n*sq - sum^2, split over two partial products
        S_SQ1: begin
          acc   <= mul_p;
          state <= S_SQ2;
        end
        S_SQ2: begin
          acc   <= acc + {mul_p[31:0], 32'd0};
          state <= S_SQ3;
        end
        S_SQ3: begin
          d     <= (acc >= mul_p) ? acc - mul_p : 64'd0;
          state <= S_SQ4;
        end
        S_SQ4: begin
          nn        <= mul_p[31:0];
          div_req   <= '{start: 1'b1, dividend: d, divisor: mul_p[31:0]};
          ret_state <= S_VAR1;
          state     <= S_DIVW;
        end

        // variance in Q.16 from quotient and scaled remainder
        S_VAR1: begin
          var_q16   <= {div_rsp.quot[47:0], 16'd0};
          div_req   <= '{start: 1'b1, dividend: {16'd0, div_rsp.rem, 16'd0}, divisor: nn};
          ret_state <= S_VAR2;
          state     <= S_DIVW;
        end
        S_VAR2: begin
          sqrt_req <= '{start: 1'b1, radicand: var_c};
          state    <= S_SQRTW;
        end
        S_SQRTW: begin
          if (sqrt_rsp.done) begin
            std_q8 <= (sqrt_rsp.root < floor_q8) ? floor_q8 : sqrt_rsp.root;
            state  <= S_Y;
          end
        end

        // y = |elapsed - mean| / std, clamped to 16
        S_Y: begin
          neg <= neg_c;
          if (y_big) begin
            y     <= Y_MAX_Q16;
            state <= S_Y2;
          end else begin
            div_req   <= '{start: 1'b1, dividend: {mag_c[47:0], 16'd0}, divisor: std_q8};
            ret_state <= S_YR;
            state     <= S_DIVW;
          end
        end
        S_YR: begin
          y     <= div_rsp.quot[31:0];
          state <= S_Y2;
        end
        S_Y2: state <= S_Y3;
        S_Y3: state <= S_Y4;
        S_Y4: state <= S_Y5;
        S_Y5: begin
          if (!neg && tm_c >= INF_T_Q16) begin
            phi   <= PHI_SAT;
            state <= S_AVAIL;
          end else begin
            x         <= x_c;
            div_req   <= '{start: 1'b1, dividend: x_c, divisor: LN2_Q30};
            ret_state <= S_EXP0;
            state     <= S_DIVW;
          end
        end

        // exp(-x): ln2 range reduction, remainder feeds the Taylor series
        S_EXP0: begin
          if (div_rsp.quot >= EXP_K_LIMIT) begin
            u     <= '0;
            state <= S_LN0;
          end else begin
            k     <= div_rsp.quot[4:0];
            r     <= div_rsp.rem;
            term  <= ONE_Q30;
            s     <= 34'(ONE_Q30);
            it    <= 4'd1;
            state <= S_EXP1;
          end
        end
        S_EXP1: state <= S_EXP2;
        S_EXP2: begin
          div_req   <= '{start: 1'b1, dividend: 64'(mul_p[63:30]), divisor: 32'(it)};
          ret_state <= S_EXP3;
          state     <= S_DIVW;
        end
        S_EXP3: begin
          term <= div_rsp.quot[31:0];
          s    <= it[0] ? s - div_rsp.quot[33:0] : s + div_rsp.quot[33:0];
          if (it == TAYLOR_TERMS) begin
            state <= S_EXP4;
          end else begin
            it    <= it + 4'd1;
            state <= S_EXP1;
          end
        end
        S_EXP4: begin
          u     <= s[33] ? 32'd0 : (s[31:0] >> k);
          state <= S_LN0;
        end

        // ln(1+u) = 2*atanh(u/(2+u))
        S_LN0: begin
          div_req   <= '{start: 1'b1, dividend: {2'd0, u, 30'd0}, divisor: TWO_Q30 + u};
          ret_state <= S_LN1;
          state     <= S_DIVW;
        end
        S_LN1: begin
          p     <= div_rsp.quot[31:0];
          ls    <= '0;
          it    <= '0;
          state <= S_LN2;
        end
        S_LN2: begin
          z2    <= mul_p[61:30];
          state <= S_LN3;
        end
        S_LN3: begin
          div_req   <= '{start: 1'b1, dividend: 64'(p), divisor: {27'd0, it, 1'b1}};
          ret_state <= S_LN4;
          state     <= S_DIVW;
        end
        S_LN4: begin
          ls    <= ls + {8'd0, div_rsp.quot[31:0]};
          state <= S_LN5;
        end
        S_LN5: begin
          p <= mul_p[61:30];
          if (it == ATANH_LAST) begin
            state <= S_PHI;
          end else begin
            it    <= it + 4'd1;
            state <= S_LN3;
          end
        end

        // phi = total / ln10 in Q8.8, rounded half up
        S_PHI: begin
          div_req   <= '{start: 1'b1,
                         dividend: {total_c[55:0], 8'd0} + 64'(LN10_Q30 >> 1),
                         divisor: LN10_Q30};
          ret_state <= S_PHIR;
          state     <= S_DIVW;
        end
        S_PHIR: begin
          phi   <= (|div_rsp.quot[63:16]) ? PHI_SAT : div_rsp.quot[15:0];
          state <= S_AVAIL;
        end

        S_AVAIL: begin
          avail <= phi < phi_threshold;
          state <= S_UPD;
        end

        // window update for a heartbeat
        S_UPD: begin
          if (cmd == 1'b0) begin
            last_beat_time <= now;
            if (last_beat_time == 48'd0) begin
              write_slot          <= '0;
              sample_count        <= '0;
              interval_sum        <= '0;
              interval_square_sum <= '0;
              app_v               <= INTERVAL_W'(first_interval_estimate - est_q);
              seed_second         <= 1'b1;
              state               <= S_APP;
            end else if (avail) begin
              app_v <= (elapsed > 48'(INTERVAL_CAP)) ? INTERVAL_CAP : elapsed[INTERVAL_W-1:0];
              taken <= 1'b1;
              state <= S_APP;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_OUT;
          end
        end

        // drop oldest entries until there is room
        S_APP: begin
          if (sample_count >= eff_len) begin
            state <= S_EV1;
          end else begin
            state <= S_WR;
          end
        end
        S_EV1: begin
          old   <= ram_rdata;
          state <= S_EV2;
        end
        S_EV2: begin
          interval_sum        <= interval_sum - 40'(old);
          interval_square_sum <= interval_square_sum - mul_p;
          sample_count        <= sample_count - CNT_W'(1);
          state               <= S_APP;
        end
        S_WR: state <= S_WR2;
        S_WR2: begin
          interval_sum        <= interval_sum + 40'(app_v);
          interval_square_sum <= interval_square_sum + mul_p;
          write_slot          <= (write_slot == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                 : write_slot + ADDR_W'(1);
          sample_count        <= sample_count + CNT_W'(1);
          if (seed_second) begin
            seed_second <= 1'b0;
            app_v       <= INTERVAL_W'(17'(first_interval_estimate) + 17'(est_q));
            state       <= S_APP;
          end else begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            phi_level      <= phi;
            available      <= avail;
            interval_taken <= taken;
            state          <= S_IDLE;
          end
        end

        S_DIVW: begin
          if (div_rsp.done) begin
            state <= ret_state;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // window occupancy stays within bounds between items
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (sample_count >= CNT_W'(2) && sample_count <= CNT_W'(WINDOW_DEPTH)))
    else $error("sample count out of range while idle");

  // an interval only enters the window while the peer is available
  a_taken_avail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!interval_taken || available))
    else $error("interval taken while unavailable");

  // a new result beat is only launched from the output state
  a_out_launch: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result launched outside output state");

  // divider is only started on the way into the wait state
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> state == S_DIVW)
    else $error("divider started outside wait state");

endmodule

// File: verif/pafd_checker.sv
`timescale 1ns / 1ps

module pafd_checker import pafd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   command,
  input  logic [47:0]            now_ms,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [15:0]            phi_level,
  input  logic                   available,
  input  logic                   interval_taken,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending
);

  localparam int DEPTH = 128;
  localparam bit CMD_BEAT = 1'b0;

  typedef struct packed {
    logic [15:0] phi;
    logic        avail;
    logic        taken;
  } verdict_t;

  verdict_t    verdict_q[$];

  logic [15:0] thresh, min_std, first_est;
  logic [7:0]  win_len;
  logic [31:0] intervals[DEPTH];
  int unsigned slot, count;
  bit   [63:0] sum, sqsum, last_beat;

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] exp_neg(bit [63:0] x);
    bit [63:0] k, r, term;
    longint s;
    k = x / LN2_Q30;
    term = 64'd1 << 30;
    s = 64'sd1 << 30;
    if (k >= EXP_K_LIMIT) return 0;
    r = x - k * LN2_Q30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * r) >> 30) / n;
      if (n % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    return bit'(s) ? (64'(s) >> k) : (64'(s) >> k);
  endfunction

  function automatic bit [63:0] ln1p(bit [63:0] u);
    bit [63:0] z, z2, p, s;
    z = (u << 30) / ((64'd2 << 30) + u);
    z2 = (z * z) >> 30;
    p = z;
    s = 0;
    for (int k = 0; k < 12; k++) begin
      s += p / (2 * k + 1);
      p = (p * z2) >> 30;
    end
    return 2 * s;
  endfunction

  function automatic int unsigned eff_len();
    int unsigned l;
    l = win_len;
    if (l < 2) l = 2;
    if (l > DEPTH) l = DEPTH;
    return l;
  endfunction

  task automatic push_interval(bit [63:0] v);
    int unsigned l, idx;
    bit [63:0] old;
    l = eff_len();
    if (v > INTERVAL_CAP) v = INTERVAL_CAP;
    while (count >= l && count > 0) begin
      idx = (slot + DEPTH - (count % DEPTH)) % DEPTH;
      old = intervals[idx];
      sum -= old;
      sqsum -= old * old;
      count--;
    end
    intervals[slot % DEPTH] = v[31:0];
    sum += v;
    sqsum += v * v;
    slot = (slot + 1) % DEPTH;
    count++;
  endtask

  task automatic reseed();
    bit [63:0] e, q;
    e = first_est;
    q = e / 4;
    slot = 0;
    count = 0;
    sum = 0;
    sqsum = 0;
    push_interval(e - q);
    push_interval(e + q);
  endtask

  function automatic logic [15:0] suspicion(bit [63:0] t);
    bit [63:0] n, elapsed, mean, d, nn, var16, sd, fl, el, mag, y, y2, poly, tm, u, total, phi;
    bit neg;
    if (last_beat == 0) return 0;
    n = count ? count : 1;
    elapsed = t >= last_beat ? t - last_beat : 0;
    mean = (sum << 8) / n;
    d = n * sqsum;
    d = d >= sum * sum ? d - sum * sum : 0;
    nn = n * n;
    var16 = ((d / nn) << 16) + (((d % nn) << 16) / nn);
    sd = isqrt(var16);
    fl = 64'(min_std ? min_std : 16'd1) << 8;
    if (sd < fl) sd = fl;
    el = elapsed << 8;
    neg = el < mean;
    mag = neg ? mean - el : el - mean;
    y = (mag >= 16 * sd) ? 64'(Y_MAX_Q16) : (mag << 16) / sd;
    y2 = (y * y) >> 16;
    poly = COEF_A_Q16 + ((COEF_B_Q16 * y2) >> 16);
    tm = (y * poly) >> 16;
    if (!neg && tm >= INF_T_Q16) return PHI_SAT;
    u = exp_neg(tm << 14);
    total = (neg ? 64'd0 : (tm << 14)) + ln1p(u);
    phi = (total * 256 + LN10_Q30 / 2) / LN10_Q30;
    if (phi > PHI_SAT) phi = PHI_SAT;
    return phi[15:0];
  endfunction

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      thresh = PHI_THRESHOLD_RST;
      min_std = MIN_STD_RST;
      first_est = FIRST_EST_RST;
      win_len = WINDOW_LEN_RST;
      last_beat = 0;
      reseed();
      verdict_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHI_THRESHOLD: thresh = cfg_data;
          CFG_MIN_STD:       min_std = cfg_data;
          CFG_FIRST_EST:     first_est = cfg_data;
          CFG_WINDOW_LEN:    win_len = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want.phi = suspicion(now_ms);
        want.avail = want.phi < thresh;
        want.taken = 1'b0;
        if (command == CMD_BEAT) begin
          if (last_beat == 0) begin
            reseed();
          end else if (want.avail) begin
            push_interval(now_ms >= last_beat ? now_ms - last_beat : 0);
            want.taken = 1'b1;
          end
          last_beat = now_ms;
        end
        verdict_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{phi_level, available, interval_taken};
        if (verdict_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: phi %h avail %b taken %b",
                                        phi_level, available, interval_taken);
          mismatches <= mismatches + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result mismatch: phi %h/%h avail %b/%b taken %b/%b (exp/act)",
                       want.phi, got.phi, want.avail, got.avail, want.taken, got.taken);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= verdict_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pafd_pkg::*;

  localparam logic CMD_BEAT  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  // index past the last register; the block must ignore it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam bit [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   command;
  logic [47:0]            now_ms;
  logic                   out_valid;
  logic                   out_stall;
  logic [15:0]            phi_level;
  logic                   available;
  logic                   interval_taken;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     pending;

  // idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly
  int                     idle_mode;

  phi_accrual_failure_detector DUT (
    .clk, .rst, .in_valid, .in_stall, .command, .now_ms,
    .out_valid, .out_stall, .phi_level, .available, .interval_taken,
    .cfg_we, .cfg_index, .cfg_data
  );

  pafd_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .command, .now_ms,
    .out_valid, .out_stall, .phi_level, .available, .interval_taken,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure follows the current idle pattern
  always @(posedge clk) begin
    case (idle_mode)
      2:       out_stall <= $urandom_range(99) < 73;
      3:       out_stall <= $urandom_range(99) < 13;
      default: out_stall <= 1'b0;
    endcase
  end

  initial begin
    #400_000_000;
    $display("status: fail");
    $finish;
  end

  // one beat on the request channel; returns at the edge that accepted it
  task automatic send(logic cmd, logic [47:0] t);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 73 : (idle_mode == 3) ? 13 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    now_ms   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // drain results, let the block settle, then load a new setting
  task automatic reconfigure(logic [15:0] thr, logic [15:0] sd, logic [15:0] est,
                             logic [7:0] len);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    write_reg(CFG_PHI_THRESHOLD, thr);
    write_reg(CFG_MIN_STD, sd);
    write_reg(CFG_FIRST_EST, est);
    write_reg(CFG_WINDOW_LEN, {$urandom_range(255), 8'(len)} >> 0);
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  logic [47:0] t_now, t_step;
  logic [15:0] est;
  int          roll;

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= CMD_BEAT;
    now_ms    <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PHI_THRESHOLD;
    cfg_data  <= '0;
    idle_mode  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no heartbeat yet, seeding, regular beats, far future, time backward
    send(CMD_QUERY, 48'd5000);
    send(CMD_BEAT, 48'd1000);
    send(CMD_QUERY, 48'd1900);
    send(CMD_BEAT, 48'd2000);
    send(CMD_BEAT, 48'd3050);
    send(CMD_QUERY, 48'd3500);
    send(CMD_QUERY, 48'h8000_0000_0000);
    send(CMD_QUERY, 48'd10);
    send(CMD_BEAT, 48'd2500);
    send(CMD_BEAT, 48'd0);
    send(CMD_QUERY, 48'd700);
    send(CMD_BEAT, 48'd900);
    send(CMD_BEAT, T_MAX - 48'd100);
    send(CMD_BEAT, T_MAX);
    send(CMD_QUERY, T_MAX);

    // wide tolerance so ever longer intervals are taken until they hit the cap
    reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd6);
    t_now = 48'd1;
    t_step = 48'd300_000;
    send(CMD_BEAT, t_now);
    for (int i = 0; i < 9; i++) begin
      t_now += t_step;
      t_step = t_step + t_step / 2;
      send(CMD_BEAT, t_now);
    end

    // random phases, extremes first
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: reconfigure(PHI_THRESHOLD_RST, MIN_STD_RST, FIRST_EST_RST, 8'd128);
        1: reconfigure(16'd0, 16'd0, 16'd4, 8'd2);
        2: reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
        3: reconfigure(16'($urandom_range(300, 3000)), 16'($urandom_range(1, 200)),
                       16'($urandom_range(0, 3)), 8'($urandom_range(0, 1)));
        4: reconfigure(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        default: reconfigure(16'($urandom_range(200, 4000)), 16'($urandom_range(1, 400)),
                             16'($urandom_range(4, 3000)), 8'($urandom_range(2, 16)));
      endcase
      est = checker_i.first_est;
      t_now = {1'b0, 15'($urandom), 32'($urandom)} + 48'd1;
      for (int i = 0; i < 105; i++) begin
        if (i % 30 == 0) idle_mode = $urandom_range(3);
        roll = $urandom_range(99);
        if (roll < 55) begin
          // regular heartbeat around the estimate, sometimes a long gap
          t_step = est + $urandom_range(est / 2) - est / 4;
          if ($urandom_range(9) == 0) t_step = t_step * $urandom_range(3, 20);
          t_now += t_step;
          send(CMD_BEAT, t_now);
        end else if (roll < 85) begin
          send(CMD_QUERY, t_now + $urandom_range(2 * est + 1));
        end else if (roll < 90) begin
          send(CMD_QUERY, t_now - $urandom_range(est + 1));
        end else if (roll < 93) begin
          send(CMD_BEAT, 48'd0);
          t_now = 48'd0;
        end else begin
          t_now = {16'($urandom), 32'($urandom)};
          send($urandom_range(1), t_now);
        end
      end
      idle_mode = 0;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
